// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the date difference block.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked at every rising edge outside of reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Expression that must never be true outside of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== src/cdd_pkg.sv =====
// Shared types, constants and month tables of the calendar date difference block.
// Depends on nothing.
package cdd_pkg;

  localparam int unsigned YEAR_W    = 14;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned DAY_W     = 5;
  localparam int unsigned DAY_NUM_W = 22;
  localparam int unsigned DIFF_W    = 22;
  localparam int unsigned CUM_W     = 9;
  localparam int unsigned Q100_W    = 7;
  localparam int unsigned RECIP_W   = 13;
  localparam int unsigned PROD_W    = YEAR_W + RECIP_W;

  localparam logic [YEAR_W-1:0]  YEAR_FLOOR = 14'd1900;
  localparam logic [YEAR_W-1:0]  YEAR_CEIL  = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST  = 5'd1;
  localparam logic [DAY_W-1:0]   FEB_LEAP_LEN = 5'd29;

  // floor(x / 100) == (x * 5243) >> 19 for every x below 2^14.
  localparam logic [RECIP_W-1:0] RECIP_100  = 13'd5243;
  localparam int unsigned        RECIP_SHIFT = 19;
  localparam logic [YEAR_W-1:0]  HUNDRED    = 14'd100;
  localparam logic [DAY_NUM_W-1:0] DAYS_PER_YEAR = 22'd365;

  localparam logic [DIFF_W-1:0]  DIFF_MAX = 22'd2958463;

  // Length of each month in a common year, indexed by month number.
  localparam logic [DAY_W-1:0] MONTH_DAYS [0:12] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Days of all full months before a month in a common year.
  localparam logic [CUM_W-1:0] CUM_DAYS [0:12] = '{
    9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // Per-stage advance strobes of the pipeline.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } adv_t;

endpackage

// ===== src/cdd_pipe_ctrl.sv =====
// Valid bits and stall control of the four-stage date difference pipeline.
// Depends on cdd_pkg.
module cdd_pipe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cdd_pkg::adv_t adv_o
);

  logic [3:0] valid_q, valid_d;
  cdd_pkg::adv_t adv;

  // A stage loads when it is empty or its content moves on in the same cycle,
  // so bubbles collapse and a stall never drops or repeats a word.
  always_comb begin
    adv.s4 = !valid_q[3] || out_ready_i;
    adv.s3 = !valid_q[2] || adv.s4;
    adv.s2 = !valid_q[1] || adv.s3;
    adv.s1 = !valid_q[0] || adv.s2;
  end

  always_comb begin
    valid_d[0] = adv.s1 ? in_valid_i : valid_q[0];
    valid_d[1] = adv.s2 ? valid_q[0] : valid_q[1];
    valid_d[2] = adv.s3 ? valid_q[1] : valid_q[2];
    valid_d[3] = adv.s4 ? valid_q[2] : valid_q[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign adv_o       = adv;
  assign in_ready_o  = adv.s1;
  assign out_valid_o = valid_q[3];

endmodule

// ===== src/cdd_date_conv.sv =====
// Three-stage conversion of one raw date into a day number from 0001-01-01.
// Depends on cdd_pkg for tables, constants and the advance struct.
module cdd_date_conv (
  input  logic                             clk_i,
  input  cdd_pkg::adv_t                    adv_i,
  input  logic [cdd_pkg::YEAR_W-1:0]       year_i,
  input  logic [cdd_pkg::MONTH_W-1:0]      month_i,
  input  logic [cdd_pkg::DAY_W-1:0]        day_i,
  output logic [cdd_pkg::DAY_NUM_W-1:0]    day_num_o
);

  // Stage 1: clamp year and month, and start the divide by 100.
  logic [cdd_pkg::YEAR_W-1:0]  year_d, s1_year_q;
  logic [cdd_pkg::MONTH_W-1:0] month_d, s1_month_q;
  logic [cdd_pkg::DAY_W-1:0]   s1_day_q;
  logic [cdd_pkg::PROD_W-1:0]  prod_y;
  logic [cdd_pkg::Q100_W-1:0]  q100_d, s1_q100_q;

  always_comb begin
    if (year_i < cdd_pkg::YEAR_FLOOR) begin
      year_d = cdd_pkg::YEAR_FLOOR;
    end else if (year_i > cdd_pkg::YEAR_CEIL) begin
      year_d = cdd_pkg::YEAR_CEIL;
    end else begin
      year_d = year_i;
    end
    if (month_i < cdd_pkg::MONTH_JAN || month_i > cdd_pkg::MONTH_DEC) begin
      month_d = cdd_pkg::MONTH_JAN;
    end else begin
      month_d = month_i;
    end
    prod_y = {{cdd_pkg::RECIP_W{1'b0}}, year_d} *
             {{cdd_pkg::YEAR_W{1'b0}}, cdd_pkg::RECIP_100};
    q100_d = prod_y[cdd_pkg::RECIP_SHIFT +: cdd_pkg::Q100_W];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      s1_year_q  <= year_d;
      s1_month_q <= month_d;
      s1_day_q   <= day_i;
      s1_q100_q  <= q100_d;
    end
  end

  // Stage 2: leap rule, day check, month table and the year terms.
  logic                           div100, div400, leap;
  logic [cdd_pkg::YEAR_W-1:0]     back100, prev_year;
  logic [cdd_pkg::DAY_W-1:0]      lim, day_d;
  logic [cdd_pkg::CUM_W-1:0]      cum_d;
  logic [cdd_pkg::DAY_NUM_W-1:0]  yr_days_d;
  logic [cdd_pkg::Q100_W-1:0]     p100_d;
  logic [cdd_pkg::Q100_W-3:0]     p400_d;

  logic [cdd_pkg::DAY_NUM_W-1:0]  s2_yr_days_q;
  logic [cdd_pkg::YEAR_W-3:0]     s2_p4_q;
  logic [cdd_pkg::Q100_W-1:0]     s2_p100_q;
  logic [cdd_pkg::Q100_W-3:0]     s2_p400_q;
  logic [cdd_pkg::CUM_W-1:0]      s2_cum_q;
  logic [cdd_pkg::DAY_W-1:0]      s2_day_q;

  always_comb begin
    back100 = {{(cdd_pkg::YEAR_W - cdd_pkg::Q100_W){1'b0}}, s1_q100_q} * cdd_pkg::HUNDRED;
    div100  = (back100 == s1_year_q);
    div400  = div100 && (s1_q100_q[1:0] == 2'b00);
    leap    = (s1_year_q[1:0] == 2'b00) && (!div100 || div400);

    if (s1_month_q == cdd_pkg::MONTH_FEB && leap) begin
      lim = cdd_pkg::FEB_LEAP_LEN;
    end else begin
      lim = cdd_pkg::MONTH_DAYS[s1_month_q];
    end
    if (s1_day_q == '0 || s1_day_q > lim) begin
      day_d = cdd_pkg::DAY_FIRST;
    end else begin
      day_d = s1_day_q;
    end

    cum_d = cdd_pkg::CUM_DAYS[s1_month_q] +
            {{(cdd_pkg::CUM_W - 1){1'b0}}, (leap && s1_month_q > cdd_pkg::MONTH_FEB)};

    // The year before this one: floor divisions follow from those of the year.
    prev_year = s1_year_q - {{(cdd_pkg::YEAR_W - 1){1'b0}}, 1'b1};
    yr_days_d = {{(cdd_pkg::DAY_NUM_W - cdd_pkg::YEAR_W){1'b0}}, prev_year} *
                cdd_pkg::DAYS_PER_YEAR;
    p100_d = s1_q100_q - {{(cdd_pkg::Q100_W - 1){1'b0}}, div100};
    p400_d = s1_q100_q[cdd_pkg::Q100_W-1:2] - {{(cdd_pkg::Q100_W - 3){1'b0}}, div400};
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      s2_yr_days_q <= yr_days_d;
      s2_p4_q      <= prev_year[cdd_pkg::YEAR_W-1:2];
      s2_p100_q    <= p100_d;
      s2_p400_q    <= p400_d;
      s2_cum_q     <= cum_d;
      s2_day_q     <= day_d;
    end
  end

  // Stage 3: sum of all terms.
  logic [cdd_pkg::DAY_NUM_W-1:0] num_d, s3_num_q;

  always_comb begin
    num_d = s2_yr_days_q
          + {{(cdd_pkg::DAY_NUM_W - cdd_pkg::YEAR_W + 2){1'b0}}, s2_p4_q}
          - {{(cdd_pkg::DAY_NUM_W - cdd_pkg::Q100_W){1'b0}}, s2_p100_q}
          + {{(cdd_pkg::DAY_NUM_W - cdd_pkg::Q100_W + 2){1'b0}}, s2_p400_q}
          + {{(cdd_pkg::DAY_NUM_W - cdd_pkg::CUM_W){1'b0}}, s2_cum_q}
          + {{(cdd_pkg::DAY_NUM_W - cdd_pkg::DAY_W){1'b0}}, s2_day_q};
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      s3_num_q <= num_d;
    end
  end

  assign day_num_o = s3_num_q;

endmodule

// ===== src/calendar_date_difference.sv =====
// Top level of the calendar date difference block.
// Depends on cdd_pkg, cdd_pipe_ctrl, cdd_date_conv and assert_macros.svh.
//
// Usage: the input channel carries one word per date pair (year, month and
// day of two Gregorian dates) under a valid/ready handshake. Each date is
// sanitized (year clamped to 1900..9999, month outside 1..12 taken as 1, a
// day invalid for its month taken as 1) and turned into a day number counted
// from 0001-01-01. The output channel carries one word per input word: the
// absolute difference of the two day numbers, in days.
// Each word passes through four register stages, the accepting edge loading
// the first: clamping and the divide-by-100 reciprocal multiply, then leap
// rule and month table, then the day number sum, then the subtract into the
// output register. Throughput is one word per cycle while the receiver keeps
// out_ready_i high; each stage holds one word and all four may be busy at
// once.
// When the receiver holds out_ready_i low, the output word stays put and the
// stages behind it keep filling empty slots; in_ready_o falls only once all
// four stages hold a word. Reset clears the valid bits, so the block comes
// up empty and ready; the data registers are not reset.
`include "assert_macros.svh"

module calendar_date_difference (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [cdd_pkg::YEAR_W-1:0]     first_year_i,
  input  logic [cdd_pkg::MONTH_W-1:0]    first_month_i,
  input  logic [cdd_pkg::DAY_W-1:0]      first_day_i,
  input  logic [cdd_pkg::YEAR_W-1:0]     second_year_i,
  input  logic [cdd_pkg::MONTH_W-1:0]    second_month_i,
  input  logic [cdd_pkg::DAY_W-1:0]      second_day_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [cdd_pkg::DIFF_W-1:0]     day_difference_o
);

  cdd_pkg::adv_t adv;
  logic [cdd_pkg::DAY_NUM_W-1:0] num_a, num_b;
  logic [cdd_pkg::DIFF_W-1:0]    diff_d, diff_q;

  // Valid bits and per-stage advance strobes.
  cdd_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .adv_o       (adv)
  );

  // The two dates run through identical converters in lockstep.
  cdd_date_conv u_conv_a (
    .clk_i     (clk_i),
    .adv_i     (adv),
    .year_i    (first_year_i),
    .month_i   (first_month_i),
    .day_i     (first_day_i),
    .day_num_o (num_a)
  );

  cdd_date_conv u_conv_b (
    .clk_i     (clk_i),
    .adv_i     (adv),
    .year_i    (second_year_i),
    .month_i   (second_month_i),
    .day_i     (second_day_i),
    .day_num_o (num_b)
  );

  // Stage 4: absolute difference into the output register.
  always_comb begin
    if (num_a >= num_b) begin
      diff_d = num_a - num_b;
    end else begin
      diff_d = num_b - num_a;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv.s4) begin
      diff_q <= diff_d;
    end
  end

  assign day_difference_o = diff_q;

  // Sanitized dates span at most 1900-01-01 to 9999-12-31.
  `ASSERT_PROP(a_diff_range, clk_i, rst_ni,
               out_valid_o |-> (day_difference_o <= cdd_pkg::DIFF_MAX))

  // Back pressure reaches the input only when the receiver stalls a full pipe.
  `ASSERT_PROP(a_stall_source, clk_i, rst_ni,
               !in_ready_o |-> (out_valid_o && !out_ready_i))

endmodule

// ===== test/calendar_date_difference_test.sv =====
// Self-checking testbench for calendar_date_difference: directed and random date pairs,
// random idling on both channels, results checked against a day-count predictor.
// Depends on cdd_pkg and the calendar_date_difference RTL.
module calendar_date_difference_test;

  // The block is slow only by its own four stages plus the idle cycles that
  // each side draws, so reaching STUCK_LIMIT without a single handshake can
  // only mean a hang.
  localparam int unsigned STUCK_LIMIT  = 3000;
  localparam int unsigned RANDOM_PAIRS = 1700;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_WAIT     = 17;

  // One calendar date as it appears on the input ports.
  typedef struct {
    logic [cdd_pkg::YEAR_W-1:0]  year;
    logic [cdd_pkg::MONTH_W-1:0] month;
    logic [cdd_pkg::DAY_W-1:0]   day;
  } date_t;

  // One input word: the two dates whose distance is asked for.
  typedef struct {
    date_t first;
    date_t second;
  } date_pair_t;

  // Scoreboard: predicts the day distance of every accepted date pair and
  // matches the words coming out of the block against those predictions in
  // order. The block keeps no state from one pair to the next, so each
  // prediction depends only on its own pair.
  class day_span_scoreboard;
    logic [cdd_pkg::DIFF_W-1:0] span_queue[$];
    int unsigned                failures;

    function new();
      failures = 0;
    endfunction

    function automatic bit is_leap(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_length(int unsigned m, bit leap);
      case (m)
        2:          return leap ? 29 : 28;
        4, 6, 9, 11: return 30;
        default:    return 31;
      endcase
    endfunction

    // Day number counted from 0001-01-01 after the date has been cleaned up:
    // the year is clamped into 1900..9999, a month outside 1..12 becomes
    // January, and a day that the month does not have becomes the first.
    function automatic int unsigned day_count(date_t dt);
      int unsigned y, m, d, p, n;
      bit          leap;
      y = 32'(dt.year);
      m = 32'(dt.month);
      d = 32'(dt.day);
      if (y < 1900) y = 1900;
      if (y > 9999) y = 9999;
      if (m < 1 || m > 12) m = 1;
      leap = is_leap(y);
      if (d < 1 || d > month_length(m, leap)) d = 1;
      p = y - 1;
      n = p * 365 + p / 4 - p / 100 + p / 400;
      for (int unsigned i = 1; i < m; i++) n += month_length(i, leap);
      return n + d;
    endfunction

    function automatic logic [cdd_pkg::DIFF_W-1:0] days_between(date_pair_t pr);
      int unsigned a, b, span;
      a = day_count(pr.first);
      b = day_count(pr.second);
      span = (a >= b) ? a - b : b - a;
      return span[cdd_pkg::DIFF_W-1:0];
    endfunction

    function void note_pair(date_pair_t pr);
      span_queue.push_back(days_between(pr));
    endfunction

    function int unsigned outstanding();
      return span_queue.size();
    endfunction

    task report_mismatch(string what);
      $display("mismatch: %s", what);
      failures++;
    endtask

    task check_span(logic [cdd_pkg::DIFF_W-1:0] got);
      logic [cdd_pkg::DIFF_W-1:0] want;
      if (span_queue.size() == 0) begin
        report_mismatch($sformatf("day_difference %0d arrived with no pair outstanding", got));
      end else begin
        want = span_queue.pop_front();
        if (got !== want)
          report_mismatch($sformatf("day_difference got %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic                          clk_i;
  logic                          rst_ni         = 1'b0;
  logic                          in_valid_i     = 1'b0;
  logic                          in_ready_o;
  logic [cdd_pkg::YEAR_W-1:0]    first_year_i   = '0;
  logic [cdd_pkg::MONTH_W-1:0]   first_month_i  = '0;
  logic [cdd_pkg::DAY_W-1:0]     first_day_i    = '0;
  logic [cdd_pkg::YEAR_W-1:0]    second_year_i  = '0;
  logic [cdd_pkg::MONTH_W-1:0]   second_month_i = '0;
  logic [cdd_pkg::DAY_W-1:0]     second_day_i   = '0;
  logic                          out_valid_o;
  logic                          out_ready_i    = 1'b0;
  logic [cdd_pkg::DIFF_W-1:0]    day_difference_o;

  day_span_scoreboard sb = new();

  // Stretch bookkeeping for the two idling processes. Each side runs through
  // stretches of 10..80 words; a stretch is either calm (no idle cycles at
  // all) or noisy (0..MAX_WAIT idle cycles drawn per word).
  int unsigned send_stretch  = 0;
  bit          send_calm     = 1'b0;
  int unsigned drain_stretch = 0;
  bit          drain_calm    = 1'b0;
  int unsigned stuck_cycles  = 0;

  calendar_date_difference dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .first_year_i     (first_year_i),
    .first_month_i    (first_month_i),
    .first_day_i      (first_day_i),
    .second_year_i    (second_year_i),
    .second_month_i   (second_month_i),
    .second_day_i     (second_day_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .day_difference_o (day_difference_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Draws the number of idle cycles before the next word, opening a new
  // calm or noisy stretch whenever the current one runs out.
  function automatic int unsigned idle_cycles(ref int unsigned stretch, ref bit calm);
    if (stretch == 0) begin
      stretch = $urandom_range(10, 80);
      calm    = ($urandom_range(0, 3) == 0);
    end
    stretch--;
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic date_pair_t make_pair(int unsigned y1, int unsigned m1, int unsigned d1,
                                           int unsigned y2, int unsigned m2, int unsigned d2);
    date_pair_t pr;
    pr.first.year   = y1[cdd_pkg::YEAR_W-1:0];
    pr.first.month  = m1[cdd_pkg::MONTH_W-1:0];
    pr.first.day    = d1[cdd_pkg::DAY_W-1:0];
    pr.second.year  = y2[cdd_pkg::YEAR_W-1:0];
    pr.second.month = m2[cdd_pkg::MONTH_W-1:0];
    pr.second.day   = d2[cdd_pkg::DAY_W-1:0];
    return pr;
  endfunction

  // Most random dates are well formed so that the month table and the leap
  // rule get exercised; the rest are raw field values or sit on the edges
  // where the cleanup rules kick in.
  function automatic date_t random_date();
    date_t       dt;
    int unsigned yr, mo, dy;
    case ($urandom_range(0, 19))
      0, 1: begin
        // Anything the ports can carry, years above 9999 included.
        yr = $urandom_range(0, 16383);
        mo = $urandom_range(0, 15);
        dy = $urandom_range(0, 31);
      end
      2, 3: begin
        yr = $urandom_range(0, 9999);
        mo = $urandom_range(0, 15);
        dy = $urandom_range(0, 31);
      end
      4: begin
        // End of February around century years, where the leap rule bites.
        yr = 100 * $urandom_range(19, 99) + $urandom_range(0, 4);
        mo = 2;
        dy = $urandom_range(27, 31);
      end
      5: begin
        // Around both year clamps.
        yr = $urandom_range(0, 1) ? $urandom_range(1890, 1910)
                                  : $urandom_range(9990, 10010);
        mo = $urandom_range(1, 12);
        dy = $urandom_range(1, 31);
      end
      6, 7: begin
        // Month ends, valid or past the end.
        yr = $urandom_range(1900, 9999);
        mo = $urandom_range(1, 12);
        dy = $urandom_range(28, 31);
      end
      default: begin
        yr = $urandom_range(1900, 9999);
        mo = $urandom_range(1, 12);
        dy = $urandom_range(1, 28);
      end
    endcase
    dt.year  = yr[cdd_pkg::YEAR_W-1:0];
    dt.month = mo[cdd_pkg::MONTH_W-1:0];
    dt.day   = dy[cdd_pkg::DAY_W-1:0];
    return dt;
  endfunction

  function automatic date_pair_t random_pair();
    date_pair_t pr;
    pr.first = random_date();
    case ($urandom_range(0, 9))
      0: pr.second = pr.first;
      1, 2: begin
        // Same year, so the distance comes mostly from the month table.
        pr.second      = random_date();
        pr.second.year = pr.first.year;
      end
      default: pr.second = random_date();
    endcase
    return pr;
  endfunction

  // Offers one word on the input channel and returns at the edge that takes
  // it. The valid bit stays high across back-to-back words; it drops only
  // when an idle gap is drawn.
  task automatic send_pair(input date_pair_t pr);
    int unsigned gap;
    gap = idle_cycles(send_stretch, send_calm);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    first_year_i   <= pr.first.year;
    first_month_i  <= pr.first.month;
    first_day_i    <= pr.first.day;
    second_year_i  <= pr.second.year;
    second_month_i <= pr.second.month;
    second_day_i   <= pr.second.day;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_pair(pr);
  endtask

  // Receiver: holds ready low for a drawn number of cycles before each word,
  // then keeps it high until a word is taken.
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = idle_cycles(drain_stretch, drain_calm);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Output monitor and hang detector. Both look at values from before the
  // edge, since every input is driven with nonblocking assignments.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_span(day_difference_o);
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed pairs: the widest distance in both orders, both year clamps,
    // bad months and days, the leap rule for ordinary, century and
    // four-century years, December, equal dates and walking field bits.
    send_pair(make_pair(1900,  1,  1, 9999, 12, 31));
    send_pair(make_pair(9999, 12, 31, 1900,  1,  1));
    send_pair(make_pair(2024,  2, 29, 2024,  2, 29));
    send_pair(make_pair(   0,  0,  0, 16383, 15, 31));
    send_pair(make_pair(1899,  6, 15, 1900,  6, 15));
    send_pair(make_pair(10000, 3,  1, 9999,  3,  1));
    send_pair(make_pair(2000,  2, 29, 2000,  3,  1));
    send_pair(make_pair(1900,  2, 29, 1900,  3,  1));
    send_pair(make_pair(2100,  2, 29, 2100,  2, 28));
    send_pair(make_pair(2023,  2, 29, 2024,  2, 29));
    send_pair(make_pair(2024,  2, 30, 2024,  2,  1));
    send_pair(make_pair(2023,  4, 31, 2023,  4, 30));
    send_pair(make_pair(2023, 13,  5, 2023,  1,  5));
    send_pair(make_pair(2023,  0, 10, 2023, 15, 10));
    send_pair(make_pair(2023, 12, 31, 2024,  1,  1));
    send_pair(make_pair(2023, 12,  0, 2023, 12,  1));
    send_pair(make_pair(8191, 11, 30, 8192,  1, 31));
    send_pair(make_pair(5461, 10, 21, 10922, 5, 10));
    send_pair(make_pair(1904,  2, 29, 1903,  2, 29));
    send_pair(make_pair(1999,  7, 31, 2001,  9, 30));

    for (int unsigned n = 0; n < RANDOM_PAIRS; n++) send_pair(random_pair());
    in_valid_i <= 1'b0;

    // Let every outstanding word come out, then give the pipeline a few
    // more cycles to show any stray word.
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
